FILE: sv/spc_pkg.sv
// Shared types, constants and the arctangent table for the polar-to-Cartesian converter.
package spc_pkg;

   // Field and datapath widths
   localparam int RANGE_WIDTH = 16;
   localparam int ANGLE_WIDTH = 16;
   localparam int COORD_WIDTH = 17;
   localparam int X_WIDTH     = 36;
   localparam int Z_WIDTH     = 34;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   // Reciprocal of the CORDIC gain, Q32
   localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74EDA8;

   // Output saturation bound
   localparam int OUT_LIMIT = 65535;

   // Arctangent table size; later iterations are not performed
   localparam int ATAN_ENTRIES = 24;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_ANGLE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANGLE_STEP  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEEP_PARITY = 2'd2;

   // Reset values of the configuration registers
   localparam logic [ANGLE_WIDTH-1:0] START_ANGLE_RESET = 16'h8000;
   localparam logic [ANGLE_WIDTH-1:0] ANGLE_STEP_RESET  = 16'd182;
   localparam logic                   KEEP_PARITY_RESET = 1'b1;

   // atan(2^-i) in units of 2^-32 turn, truncated
   localparam logic [31:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
      32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   // Rotation state handed from cell to cell
   typedef struct packed {
      logic signed [X_WIDTH-1:0] x;
      logic signed [X_WIDTH-1:0] y;
      logic signed [Z_WIDTH-1:0] z;
   } cordic_vec_type;

endpackage

FILE: sv/spc_front.sv
// Beam angle tracking, range prescale and quadrant fold ahead of the CORDIC cells.
module spc_front import spc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [RANGE_WIDTH-1:0]     req_range_mm,
   input  logic                       req_scan_start,
   output logic                       vec_valid,
   output cordic_vec_type             vec_data,
   input  logic                       vec_ready
);

   // Configuration registers
   logic [ANGLE_WIDTH-1:0] start_angle_ff;
   logic [ANGLE_WIDTH-1:0] angle_step_ff;
   logic                   keep_parity_ff;

   // Scan state
   logic [ANGLE_WIDTH-1:0] beam_angle_ff, beam_angle_in;
   logic                   index_parity_ff, index_parity_in;

   // Stage A: prescaled range and angle
   logic                   a_valid_ff;
   logic [31:0]            a_mag_ff, a_mag_in;
   logic [ANGLE_WIDTH-1:0] a_angle_ff;
   logic                   a_ready;

   // Stage B: folded vector
   logic                   b_valid_ff;
   cordic_vec_type         b_vec_ff, b_vec_in;
   logic                   b_ready;

   logic                   accept;
   logic [47:0]            product;
   logic [47:0]            product_rnd;
   logic                   fold;
   logic [ANGLE_WIDTH-1:0] angle_folded;
   logic signed [X_WIDTH-1:0] mag_ext;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_angle_ff <= START_ANGLE_RESET;
         angle_step_ff  <= ANGLE_STEP_RESET;
         keep_parity_ff <= KEEP_PARITY_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_START_ANGLE: start_angle_ff <= csr_write_data;
            CSR_ANGLE_STEP:  angle_step_ff  <= csr_write_data;
            CSR_KEEP_PARITY: keep_parity_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   assign a_ready   = !a_valid_ff || b_ready;
   assign b_ready   = !b_valid_ff || vec_ready;
   assign req_stall = !a_ready;
   assign accept    = req_valid && a_ready;

   // Advance beam angle and index parity, or restart them on req_scan_start
   always_comb begin
      if (req_scan_start) begin
         beam_angle_in   = start_angle_ff;
         index_parity_in = 1'b0;
      end else begin
         beam_angle_in   = beam_angle_ff + angle_step_ff;
         index_parity_in = !index_parity_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beam_angle_ff   <= '0;
         index_parity_ff <= 1'b0;
      end else if (accept) begin
         beam_angle_ff   <= beam_angle_in;
         index_parity_ff <= index_parity_in;
      end
   end

   // Scale range by the inverse gain, rounded to Q16
   assign product     = 48'(req_range_mm) * 48'(INV_GAIN_Q32);
   assign product_rnd = product + 48'h8000;
   assign a_mag_in    = product_rnd[47:16];

   // Stage A: drop samples of the wrong parity
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= accept && (index_parity_in == keep_parity_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_mag_ff   <= a_mag_in;
         a_angle_ff <= beam_angle_in;
      end
   end

   // Fold the left half plane onto the right one
   assign fold         = a_angle_ff[15] ^ a_angle_ff[14];
   assign angle_folded = {a_angle_ff[15] ^ fold, a_angle_ff[14:0]};
   assign mag_ext      = $signed({{(X_WIDTH-32){1'b0}}, a_mag_ff});

   always_comb begin
      b_vec_in.x = fold ? -mag_ext : mag_ext;
      b_vec_in.y = '0;
      b_vec_in.z = $signed({{(Z_WIDTH-32){angle_folded[15]}}, angle_folded, 16'h0000});
   end

   // Stage B
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready) begin
         b_vec_ff <= b_vec_in;
      end
   end

   assign vec_valid = b_valid_ff;
   assign vec_data  = b_vec_ff;

endmodule

FILE: sv/spc_cell.sv
// One CORDIC rotation iteration with its own pipeline register.
module spc_cell import spc_pkg::*; #(
   parameter int STAGE_IDX = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           up_valid,
   input  cordic_vec_type up_data,
   output logic           up_ready,
   output logic           down_valid,
   output cordic_vec_type down_data,
   input  logic           down_ready
);

   logic           valid_ff;
   cordic_vec_type vec_ff, vec_in;

   logic signed [X_WIDTH-1:0] dx;
   logic signed [X_WIDTH-1:0] dy;
   logic signed [Z_WIDTH-1:0] atan_val;

   assign up_ready = !valid_ff || down_ready;

   // Rotate toward zero residual angle
   assign dx       = up_data.y >>> STAGE_IDX;
   assign dy       = up_data.x >>> STAGE_IDX;
   assign atan_val = $signed({{(Z_WIDTH-32){1'b0}}, ATAN_TURN32[STAGE_IDX]});

   always_comb begin
      if (!up_data.z[Z_WIDTH-1]) begin
         vec_in.x = up_data.x - dx;
         vec_in.y = up_data.y + dy;
         vec_in.z = up_data.z - atan_val;
      end else begin
         vec_in.x = up_data.x + dx;
         vec_in.y = up_data.y - dy;
         vec_in.z = up_data.z + atan_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         vec_ff <= vec_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data  = vec_ff;

endmodule

FILE: sv/spc_round.sv
// Rounding, saturation and the result register.
module spc_round import spc_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   input  cordic_vec_type                up_data,
   output logic                          up_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_x_mm,
   output logic signed [COORD_WIDTH-1:0] rsp_y_mm
);

   localparam int SUM_WIDTH = X_WIDTH + 1;
   localparam int RND_WIDTH = SUM_WIDTH - 16;

   logic                          valid_ff;
   logic signed [COORD_WIDTH-1:0] x_ff, x_in;
   logic signed [COORD_WIDTH-1:0] y_ff, y_in;

   // Round half up to whole millimetres and clamp
   function automatic logic signed [COORD_WIDTH-1:0] round_sat(
      input logic signed [X_WIDTH-1:0] v
   );
      logic signed [SUM_WIDTH-1:0] sum;
      logic signed [RND_WIDTH-1:0] r;
      sum = SUM_WIDTH'(v) + SUM_WIDTH'(32768);
      r   = RND_WIDTH'(sum >>> 16);
      if (r > RND_WIDTH'(OUT_LIMIT)) begin
         round_sat = COORD_WIDTH'(OUT_LIMIT);
      end else if (r < -RND_WIDTH'(OUT_LIMIT)) begin
         round_sat = -COORD_WIDTH'(OUT_LIMIT);
      end else begin
         round_sat = COORD_WIDTH'(r);
      end
   endfunction

   assign up_ready = !valid_ff || !rsp_stall;
   assign x_in     = round_sat(up_data.x);
   assign y_in     = round_sat(up_data.y);

   // Hold the result until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_x_mm  = x_ff;
   assign rsp_y_mm  = y_ff;

endmodule

FILE: sv/scan_polar_to_cartesian_top.sv
// Top level of the laser scan polar-to-Cartesian converter.
//
//   channel  direction  handshake         payload
//   req      in         req_valid/stall   req_range_mm, req_scan_start
//   rsp      out        rsp_valid/stall   rsp_x_mm, rsp_y_mm
//   csr      in         csr_write_en      csr_index, csr_write_data
//
// One sample is taken per cycle unless req_stall is high; the stages are
// prescale, quadrant fold, one cell per iteration and the output register.
// Samples whose index parity does not match keep_parity leave as bubbles.
// Reset clears pipeline valid bits and scan state; CSRs get their reset values.
// A stall on rsp stops only the stages that are full; empty stages keep filling.
module scan_polar_to_cartesian_top import spc_pkg::*; #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [RANGE_WIDTH-1:0]        req_range_mm,
   input  logic                          req_scan_start,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_x_mm,
   output logic signed [COORD_WIDTH-1:0] rsp_y_mm
);

   localparam int NUM_CELLS = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

   logic           chain_valid [NUM_CELLS+1];
   logic           chain_ready [NUM_CELLS+1];
   cordic_vec_type chain_data  [NUM_CELLS+1];

   spc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_range_mm   (req_range_mm),
      .req_scan_start (req_scan_start),
      .vec_valid      (chain_valid[0]),
      .vec_data       (chain_data[0]),
      .vec_ready      (chain_ready[0])
   );

   // Row of rotation cells
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      spc_cell #(
         .STAGE_IDX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (chain_valid[i]),
         .up_data    (chain_data[i]),
         .up_ready   (chain_ready[i]),
         .down_valid (chain_valid[i+1]),
         .down_data  (chain_data[i+1]),
         .down_ready (chain_ready[i+1])
      );
   end

   spc_round u_round (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (chain_valid[NUM_CELLS]),
      .up_data   (chain_data[NUM_CELLS]),
      .up_ready  (chain_ready[NUM_CELLS]),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_x_mm  (rsp_x_mm),
      .rsp_y_mm  (rsp_y_mm)
   );

endmodule
